// File: rtl/boundary_tag_first_fit_allocator_macros.svh
// Assertion macros for the boundary tag first fit allocator.
// Used by the checker module; relies on clk and arst_n in the scope of use.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTFF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/btff_pkg.sv
// Package of the boundary tag first fit allocator: constants, payload types
// and the structs passed between the sequencer, the adder and the store.
package btff_pkg;

	localparam int HEAP_BYTES_DEF  = 16384;
	localparam int CHUNK_BYTES_DEF = 4096;
	localparam int WORD_BYTES      = 4;
	localparam int DW              = 36;
	localparam int TW              = 32;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [14:0] req_bytes;
		logic [13:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [13:0] block_addr;
		logic        ok;
	} rsp_t;

	typedef struct packed {
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic          sub;
	} alu_req_t;

	typedef struct packed {
		logic [DW-1:0] res;
		logic          lt;
	} alu_rsp_t;

	typedef struct packed {
		logic          we;
		logic [DW-1:0] addr;
		logic [TW-1:0] wdata;
	} mem_req_t;

endpackage

// File: rtl/boundary_tag_first_fit_allocator.sv
// Top level of the boundary tag first fit allocator.
// Depends on btff_pkg, btff_ctrl, btff_alu and btff_store.
//
// After reset the block runs a clearing pass that writes the whole heap
// store, with the prologue, the first chunk if it fits and the epilogue,
// and takes no transaction meanwhile. One transaction is handled at a time
// by a sequencer driving a single shared adder and the single port of the
// store. A free checks the address, clears the used bit in the header and
// footer and coalesces the block with free neighbours. An allocate walks
// the blocks first fit from the prologue; when none fits, the heap grows by
// a chunk, after which the walk starts again from the prologue, and the
// fitting block is then placed. The walk length, and so the rate, is set by
// how many blocks the heap holds. The result waits in an output register,
// so the sequencer goes on with the next transaction and waits in its last
// state only while an earlier result has not yet been taken.
module boundary_tag_first_fit_allocator #(
	parameter int HEAP_BYTES  = btff_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = btff_pkg::CHUNK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  btff_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output btff_pkg::rsp_t rsp
);

	btff_pkg::alu_req_t      alu_req;
	btff_pkg::alu_rsp_t      alu_rsp;
	btff_pkg::mem_req_t      mem_req;
	logic [btff_pkg::TW-1:0] rdata;

	btff_ctrl #(
		.HEAP_BYTES (HEAP_BYTES),
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.alu_req  (alu_req),
		.alu_rsp  (alu_rsp),
		.mem_req  (mem_req),
		.rdata    (rdata)
	);

	btff_alu u_alu (
		.alu_req(alu_req),
		.alu_rsp(alu_rsp)
	);

	btff_store #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_store (
		.clk    (clk),
		.mem_req(mem_req),
		.rdata  (rdata)
	);

endmodule

// File: rtl/btff_alu.sv
// Shared adder and comparator of the allocator.
// Depends on btff_pkg for the request and response structs.
module btff_alu (
	input  btff_pkg::alu_req_t alu_req,
	output btff_pkg::alu_rsp_t alu_rsp
);

	logic [btff_pkg::DW:0] ext;

	assign ext = {1'b0, alu_req.a}
		+ {1'b0, (alu_req.sub ? ~alu_req.b : alu_req.b)}
		+ {{btff_pkg::DW{1'b0}}, alu_req.sub};

	assign alu_rsp.res = ext[btff_pkg::DW-1:0];
	assign alu_rsp.lt  = alu_req.sub & ~ext[btff_pkg::DW];

endmodule

// File: rtl/btff_store.sv
// Heap word store with one port and a registered read.
// Depends on btff_pkg; accesses outside the store read as zero and are dropped.
module btff_store #(
	parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEF
) (
	input  logic                    clk,
	input  btff_pkg::mem_req_t      mem_req,
	output logic [btff_pkg::TW-1:0] rdata
);

	localparam int WORDS = HEAP_BYTES / btff_pkg::WORD_BYTES;
	localparam int IW    = $clog2(WORDS);

	logic [btff_pkg::TW-1:0] mem [WORDS];
	logic [btff_pkg::TW-1:0] rdata_q;
	logic                    range_q;
	logic                    in_range;
	logic [IW-1:0]           idx;

	assign in_range = mem_req.addr[btff_pkg::DW-1:2] < (btff_pkg::DW-2)'(WORDS);
	assign idx      = mem_req.addr[IW+1:2];

	always_ff @(posedge clk) begin
		if (mem_req.we && in_range) begin
			mem[idx] <= mem_req.wdata;
		end
		rdata_q <= mem[idx];
		range_q <= in_range;
	end

	assign rdata = range_q ? rdata_q : '0;

endmodule

// File: rtl/btff_ctrl.sv
// Sequencer of the allocator: clearing pass, fit walk, heap growth, placement,
// free and coalescing. Depends on btff_pkg and drives btff_alu and btff_store.
module btff_ctrl #(
	parameter int HEAP_BYTES  = btff_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = btff_pkg::CHUNK_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  btff_pkg::req_t          req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output btff_pkg::rsp_t          rsp,
	output btff_pkg::alu_req_t      alu_req,
	input  btff_pkg::alu_rsp_t      alu_rsp,
	output btff_pkg::mem_req_t      mem_req,
	input  logic [btff_pkg::TW-1:0] rdata
);

	localparam int DW    = btff_pkg::DW;
	localparam int TW    = btff_pkg::TW;
	localparam int WB    = btff_pkg::WORD_BYTES;
	localparam int WORDS = HEAP_BYTES / WB;
	localparam int CNT_W = $clog2(WORDS);
	localparam int CS    = ((CHUNK_BYTES / WB + 1) / 2) * 2 * WB;
	localparam bit FITS  = (4 * WB + CS) <= HEAP_BYTES;
	localparam int BRK0  = FITS ? (4 * WB + CS) : (4 * WB);

	localparam logic [DW-1:0] C_W    = DW'(WB);
	localparam logic [DW-1:0] C_D    = DW'(2 * WB);
	localparam logic [DW-1:0] C_MIN  = DW'(4 * WB);
	localparam logic [DW-1:0] C_CS   = DW'(CS);
	localparam logic [DW-1:0] C_HEAP = DW'(HEAP_BYTES);

	localparam logic RET_FREE = 1'b0;
	localparam logic RET_GROW = 1'b1;

	localparam logic [5:0] ST_INIT = 6'd0,  ST_IDLE = 6'd1,  ST_NEED = 6'd2,
		ST_FCHK = 6'd3,  ST_FHA = 6'd4,  ST_FHD = 6'd5,  ST_FFA = 6'd6,  ST_FFW = 6'd7,
		ST_M0 = 6'd8,  ST_M1 = 6'd9,  ST_M2 = 6'd10, ST_M3 = 6'd11, ST_M4 = 6'd12,
		ST_M5 = 6'd13, ST_M6 = 6'd14, ST_M7 = 6'd15,
		ST_MA1 = 6'd16, ST_MA2 = 6'd17, ST_MA3 = 6'd18,
		ST_MB1 = 6'd19, ST_MB2 = 6'd20, ST_MB3 = 6'd21,
		ST_MC1 = 6'd22, ST_MC2 = 6'd23, ST_MC3 = 6'd24, ST_MC4 = 6'd25,
		ST_RET = 6'd26, ST_FIT1 = 6'd27, ST_FIT2 = 6'd28, ST_FIT3 = 6'd29, ST_FIT4 = 6'd30,
		ST_G0 = 6'd31, ST_G1 = 6'd32, ST_G2 = 6'd33, ST_G3 = 6'd34, ST_G4 = 6'd35,
		ST_P0 = 6'd36, ST_P1 = 6'd37, ST_P2 = 6'd38, ST_P3 = 6'd39,
		ST_S2 = 6'd40, ST_S3 = 6'd41, ST_S4 = 6'd42, ST_S5 = 6'd43, ST_S6 = 6'd44,
		ST_DONE = 6'd45;

	logic [5:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    brk_q, bp_q, sz_q, need_q, prev_q, next_q, psz_q, nsz_q, tot_q, t_q;
	logic             pu_q, nu_q, ret_q;
	btff_pkg::req_t   req_q;
	logic [13:0]      res_addr_q;
	logic             res_ok_q;
	logic             rsp_valid_q;
	btff_pkg::rsp_t   rsp_q;
	logic [DW-1:0]    rd_size;

	function automatic logic [TW-1:0] tag(input logic [DW-1:0] x, input logic u);
		return {x[TW-1:3], 2'b00, u};
	endfunction

	function automatic logic [TW-1:0] init_word(input logic [CNT_W-1:0] i);
		logic [TW-1:0] v;
		v = '0;
		if (i == CNT_W'(1) || i == CNT_W'(2)) begin
			v = tag(C_D, 1'b1);
		end else if (FITS) begin
			if (i == CNT_W'(3) || i == CNT_W'((2 * WB + CS) / WB)) begin
				v = tag(C_CS, 1'b0);
			end else if (i == CNT_W'((3 * WB + CS) / WB)) begin
				v = tag('0, 1'b1);
			end
		end else if (i == CNT_W'(3)) begin
			v = tag('0, 1'b1);
		end
		return v;
	endfunction

	assign rd_size   = DW'({rdata[TW-1:3], 3'b000});
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		alu_req.a     = '0;
		alu_req.b     = '0;
		alu_req.sub   = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.wdata = '0;
		mem_req.addr  = alu_rsp.res;
		unique case (state_q)
			ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = init_word(cnt_q);
				mem_req.addr  = DW'({cnt_q, 2'b00});
			end
			ST_NEED: begin
				alu_req.a = DW'(req_q.req_bytes);
				alu_req.b = DW'(15);
			end
			ST_FCHK: begin
				alu_req.a = DW'(req_q.free_addr); alu_req.b = brk_q; alu_req.sub = 1'b1;
			end
			ST_FHA, ST_M0, ST_FIT2: begin
				alu_req.a = bp_q; alu_req.b = C_W; alu_req.sub = 1'b1;
			end
			ST_FHD: begin
				alu_req.a = bp_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we    = rdata[0];
				mem_req.wdata = {rdata[TW-1:3], 3'b000};
			end
			ST_FFA, ST_M3, ST_MA2, ST_MB1, ST_FIT4, ST_P2: begin
				alu_req.a = bp_q; alu_req.b = sz_q;
			end
			ST_FFW, ST_MA3: begin
				alu_req.a = t_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(sz_q, 1'b0);
			end
			ST_M1: begin
				alu_req.a = bp_q; alu_req.b = C_D; alu_req.sub = 1'b1;
			end
			ST_M2: begin
				alu_req.a = bp_q; alu_req.b = rd_size; alu_req.sub = 1'b1;
			end
			ST_M4: begin
				alu_req.a = prev_q; alu_req.b = C_W; alu_req.sub = 1'b1;
			end
			ST_M5: begin
				alu_req.a = next_q; alu_req.b = C_W; alu_req.sub = 1'b1;
			end
			ST_M7: begin
				alu_req.a = sz_q; alu_req.b = pu_q ? nsz_q : psz_q;
			end
			ST_MA1: begin
				alu_req.a = bp_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(sz_q, 1'b0);
			end
			ST_MB2, ST_MC4: begin
				alu_req.a = t_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(tot_q, 1'b0);
			end
			ST_MB3, ST_MC2: begin
				alu_req.a = prev_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(tot_q, 1'b0);
			end
			ST_MC1: begin
				alu_req.a = tot_q; alu_req.b = nsz_q;
			end
			ST_MC3: begin
				alu_req.a = next_q; alu_req.b = nsz_q;
			end
			ST_FIT1: begin
				alu_req.a = bp_q; alu_req.b = brk_q; alu_req.sub = 1'b1;
			end
			ST_FIT3: begin
				alu_req.a = rd_size; alu_req.b = need_q; alu_req.sub = 1'b1;
			end
			ST_G0: begin
				alu_req.a = brk_q; alu_req.b = C_CS;
			end
			ST_G1: begin
				alu_req.a = C_HEAP; alu_req.b = t_q; alu_req.sub = 1'b1;
			end
			ST_G2: begin
				alu_req.a = bp_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(C_CS, 1'b0);
			end
			ST_G3: begin
				alu_req.a = t_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(C_CS, 1'b0);
			end
			ST_G4: begin
				alu_req.a = t_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag('0, 1'b1);
			end
			ST_P0: begin
				alu_req.a = sz_q; alu_req.b = need_q; alu_req.sub = 1'b1;
			end
			ST_P1: begin
				alu_req.a = bp_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.wdata = (t_q < C_MIN) ? tag(sz_q, 1'b1) : tag(need_q, 1'b1);
			end
			ST_P3: begin
				alu_req.a = t_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(sz_q, 1'b1);
			end
			ST_S2: begin
				alu_req.a = bp_q; alu_req.b = need_q;
			end
			ST_S3: begin
				alu_req.a = next_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(need_q, 1'b1);
			end
			ST_S4: begin
				alu_req.a = next_q; alu_req.b = C_W; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(psz_q, 1'b0);
			end
			ST_S5: begin
				alu_req.a = next_q; alu_req.b = psz_q;
			end
			ST_S6: begin
				alu_req.a = t_q; alu_req.b = C_D; alu_req.sub = 1'b1;
				mem_req.we = 1'b1; mem_req.wdata = tag(psz_q, 1'b0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			brk_q       <= DW'(BRK0);
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						bp_q  <= DW'(req.free_addr);
						if (req.req_type == btff_pkg::REQ_FREE) begin
							state_q <= ST_FCHK;
						end else if (req.req_bytes == '0) begin
							res_addr_q <= '0; res_ok_q <= 1'b0; state_q <= ST_DONE;
						end else begin
							state_q <= ST_NEED;
						end
					end
				end
				ST_NEED: begin
					need_q  <= (req_q.req_bytes <= 15'd8) ? C_MIN
						: {alu_rsp.res[DW-1:3], 3'b000};
					bp_q    <= C_D;
					state_q <= ST_FIT1;
				end
				ST_FCHK: begin
					if (req_q.free_addr[2:0] != 3'b000 || req_q.free_addr < 14'd16
						|| !alu_rsp.lt) begin
						res_addr_q <= '0; res_ok_q <= 1'b0; state_q <= ST_DONE;
					end else begin
						state_q <= ST_FHA;
					end
				end
				ST_FHA: state_q <= ST_FHD;
				ST_FHD: begin
					if (!rdata[0]) begin
						res_addr_q <= '0; res_ok_q <= 1'b0; state_q <= ST_DONE;
					end else begin
						sz_q <= rd_size; state_q <= ST_FFA;
					end
				end
				ST_FFA: begin t_q <= alu_rsp.res; state_q <= ST_FFW; end
				ST_FFW: begin ret_q <= RET_FREE; state_q <= ST_M0; end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin sz_q <= rd_size; state_q <= ST_M2; end
				ST_M2: begin prev_q <= alu_rsp.res; state_q <= ST_M3; end
				ST_M3: begin next_q <= alu_rsp.res; state_q <= ST_M4; end
				ST_M4: state_q <= ST_M5;
				ST_M5: begin pu_q <= rdata[0]; psz_q <= rd_size; state_q <= ST_M6; end
				ST_M6: begin nu_q <= rdata[0]; nsz_q <= rd_size; state_q <= ST_M7; end
				ST_M7: begin
					if (pu_q && nu_q) begin
						state_q <= ST_RET;
					end else if (pu_q) begin
						sz_q <= alu_rsp.res; state_q <= ST_MA1;
					end else begin
						tot_q   <= alu_rsp.res;
						state_q <= nu_q ? ST_MB1 : ST_MC1;
					end
				end
				ST_MA1: state_q <= ST_MA2;
				ST_MA2: begin t_q <= alu_rsp.res; state_q <= ST_MA3; end
				ST_MA3: state_q <= ST_RET;
				ST_MB1: begin t_q <= alu_rsp.res; state_q <= ST_MB2; end
				ST_MB2: state_q <= ST_MB3;
				ST_MB3: state_q <= ST_RET;
				ST_MC1: begin tot_q <= alu_rsp.res; state_q <= ST_MC2; end
				ST_MC2: state_q <= ST_MC3;
				ST_MC3: begin t_q <= alu_rsp.res; state_q <= ST_MC4; end
				ST_MC4: state_q <= ST_RET;
				ST_RET: begin
					if (ret_q == RET_FREE) begin
						res_addr_q <= '0; res_ok_q <= 1'b1; state_q <= ST_DONE;
					end else begin
						bp_q <= C_D; state_q <= ST_FIT1;
					end
				end
				ST_FIT1: state_q <= alu_rsp.lt ? ST_FIT2 : ST_G0;
				ST_FIT2: state_q <= ST_FIT3;
				ST_FIT3: begin
					sz_q <= rd_size;
					if (rd_size == '0) begin
						state_q <= ST_G0;
					end else if (!alu_rsp.lt && !rdata[0]) begin
						state_q <= ST_P0;
					end else begin
						state_q <= ST_FIT4;
					end
				end
				ST_FIT4: begin bp_q <= alu_rsp.res; state_q <= ST_FIT1; end
				ST_G0: begin t_q <= alu_rsp.res; state_q <= ST_G1; end
				ST_G1: begin
					if (alu_rsp.lt) begin
						res_addr_q <= '0; res_ok_q <= 1'b0; state_q <= ST_DONE;
					end else begin
						bp_q <= brk_q; brk_q <= t_q; state_q <= ST_G2;
					end
				end
				ST_G2: state_q <= ST_G3;
				ST_G3: state_q <= ST_G4;
				ST_G4: begin ret_q <= RET_GROW; state_q <= ST_M0; end
				ST_P0: begin t_q <= alu_rsp.res; state_q <= ST_P1; end
				ST_P1: begin
					if (t_q < C_MIN) begin
						state_q <= ST_P2;
					end else begin
						psz_q <= t_q; state_q <= ST_S2;
					end
				end
				ST_P2: begin t_q <= alu_rsp.res; state_q <= ST_P3; end
				ST_P3: begin res_addr_q <= bp_q[13:0]; res_ok_q <= 1'b1; state_q <= ST_DONE; end
				ST_S2: begin next_q <= alu_rsp.res; state_q <= ST_S3; end
				ST_S3: state_q <= ST_S4;
				ST_S4: state_q <= ST_S5;
				ST_S5: begin t_q <= alu_rsp.res; state_q <= ST_S6; end
				ST_S6: begin res_addr_q <= bp_q[13:0]; res_ok_q <= 1'b1; state_q <= ST_DONE; end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.block_addr <= res_addr_q;
						rsp_q.ok         <= res_ok_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/btff_checker.sv
// Port checker of the boundary tag first fit allocator, bound to the top level.
// Depends on btff_pkg and the assertion macros header.
`include "boundary_tag_first_fit_allocator_macros.svh"

module btff_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input btff_pkg::rsp_t rsp
);

	`BTFF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`BTFF_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after transaction")
	`BTFF_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.ok, rsp.block_addr == 14'd0, "failure address")
	`BTFF_ASSERT_NOW(a_aligned, rsp_valid, rsp.block_addr[2:0] == 3'd0, "unaligned address")

endmodule

bind boundary_tag_first_fit_allocator btff_checker u_btff_checker (.*);
